@@ rtl/woa_pkg.sv @@
// Package for the windowed observation aggregator: payload structs, opcodes,
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package woa_pkg;

   localparam int DEPTH_DEF   = 64;
   localparam int SECTORS_DEF = 16;
   localparam int WIN_W       = 7;
   localparam logic [WIN_W-1:0] WIN_RESET = 7'd64;

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_AGG = 1'b1;

   typedef struct packed {
      logic        opcode;
      logic [15:0] obs_speed;
      logic [31:0] obs_time;
      logic [7:0]  wind_sector;
   } req_type;

   typedef struct packed {
      logic [15:0] average_speed;
      logic [15:0] gust_speed;
      logic [31:0] gust_time;
      logic [7:0]  gust_sector;
      logic [3:0]  top_sector;
      logic [31:0] elapsed;
      logic        empty_res;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic write_entry;   // write request fields at the write slot
      logic scan_clear;    // clear accumulators, start scan at entry 0
      logic scan_read;     // issue read of scan index, advance it
      logic scan_acc;      // fold registered read data into accumulators
      logic vote_clear;    // start sector vote at sector 1
      logic vote_step;     // compare one sector counter, advance
      logic div_start;     // load divider
      logic div_step;      // one restoring division step
      logic rsp_load;      // load result register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic scan_last;     // scan index is the last entry to read
      logic vote_last;     // current sector is the last one
      logic div_done;      // divider finished
      logic empty;         // fill count is zero
   } sts_type;

endpackage

@@ rtl/woa_ram.sv @@
// Generic simple dual-port RAM (one write port, one read port) with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module woa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/woa_datapath.sv @@
// Datapath: entry stores, fill/slot counters, scan accumulators, sector
// counters, serial divider and result register. Uses woa_pkg and woa_ram.
`timescale 1ns / 1ps
module woa_datapath #(
   parameter int DEPTH   = woa_pkg::DEPTH_DEF,
   parameter int SECTORS = woa_pkg::SECTORS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr,
   input  logic [woa_pkg::WIN_W-1:0]  csr_data,
   input  woa_pkg::req_type           req_data,
   input  woa_pkg::cmd_type           cmd,
   output woa_pkg::sts_type           sts,
   output woa_pkg::rsp_type           rsp_data
);
   localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int SW  = $clog2(SECTORS);
   localparam int SUMW = 16 + CW;
   localparam int DCW = $clog2(SUMW + 1);

   logic [woa_pkg::WIN_W-1:0] win_ff;
   logic [AW-1:0] slot_ff, slot_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] size;

   // Clamp window size to 1..DEPTH
   always_comb begin
      if (win_ff == '0) begin
         size = CW'(1);
      end else if (32'(win_ff) > DEPTH) begin
         size = CW'(DEPTH);
      end else begin
         size = CW'(win_ff);
      end
   end

   logic [AW-1:0] wr_slot;
   always_comb begin
      wr_slot = (CW'(slot_ff) >= size) ? '0 : slot_ff;
      slot_in = (CW'(wr_slot) + CW'(1) >= size) ? '0 : AW'(CW'(wr_slot) + CW'(1));
      fill_in = (fill_ff < size) ? fill_ff + CW'(1) : fill_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff  <= woa_pkg::WIN_RESET;
         slot_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (csr_wr) begin
            win_ff <= csr_data;
         end
         if (cmd.write_entry) begin
            slot_ff <= slot_in;
            fill_ff <= fill_in;
         end
      end
   end

   // Scan address
   logic [CW-1:0] idx_ff;
   logic [15:0] rd_speed;
   logic [31:0] rd_time;
   logic [7:0]  rd_sector;

   woa_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_speed (
      .clock, .wr_en(cmd.write_entry), .wr_addr(wr_slot),
      .wr_data(req_data.obs_speed), .rd_addr(idx_ff[AW-1:0]), .rd_data(rd_speed));
   woa_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_time (
      .clock, .wr_en(cmd.write_entry), .wr_addr(wr_slot),
      .wr_data(req_data.obs_time), .rd_addr(idx_ff[AW-1:0]), .rd_data(rd_time));
   woa_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_sector (
      .clock, .wr_en(cmd.write_entry), .wr_addr(wr_slot),
      .wr_data(req_data.wind_sector), .rd_addr(idx_ff[AW-1:0]),
      .rd_data(rd_sector));

   logic [SUMW-1:0] sum_ff;
   logic [15:0] gust_ff;
   logic [31:0] gust_t_ff, tmin_ff, tmax_ff;
   logic [7:0]  gust_s_ff;
   logic [CW-1:0] cnt_ff [SECTORS];
   logic [CW-1:0] best_cnt_ff;
   logic [SW-1:0] best_ff, vsec_ff;

   always_ff @(posedge clock) begin
      if (cmd.scan_clear) begin
         idx_ff <= '0;
      end else if (cmd.scan_read) begin
         idx_ff <= idx_ff + CW'(1);
      end
      if (cmd.scan_clear) begin
         sum_ff    <= '0;
         gust_ff   <= '0;
         gust_t_ff <= '0;
         gust_s_ff <= '0;
         tmin_ff   <= '0;
         tmax_ff   <= '0;
         for (int i = 0; i < SECTORS; i++) begin
            cnt_ff[i] <= '0;
         end
      end else if (cmd.scan_acc) begin
         sum_ff <= sum_ff + SUMW'(rd_speed);
         if (rd_speed >= gust_ff) begin
            gust_ff   <= rd_speed;
            gust_t_ff <= rd_time;
            gust_s_ff <= rd_sector;
         end
         if (rd_sector != 8'd0 && 32'(rd_sector) < SECTORS) begin
            cnt_ff[rd_sector[SW-1:0]] <= cnt_ff[rd_sector[SW-1:0]] + CW'(1);
         end
         if (tmin_ff == '0 || rd_time < tmin_ff) begin
            tmin_ff <= rd_time;
         end
         if (rd_time > tmax_ff) begin
            tmax_ff <= rd_time;
         end
      end
      // Sector vote: one counter per cycle
      if (cmd.vote_clear) begin
         vsec_ff     <= SW'(1);
         best_ff     <= '0;
         best_cnt_ff <= '0;
      end else if (cmd.vote_step) begin
         vsec_ff <= vsec_ff + SW'(1);
         if (cnt_ff[vsec_ff] > best_cnt_ff) begin
            best_cnt_ff <= cnt_ff[vsec_ff];
            best_ff     <= vsec_ff;
         end
      end
   end

   // Restoring divider: sum / fill, one quotient bit per cycle
   logic [SUMW-1:0] quo_ff;
   logic [CW:0]     rem_ff;
   logic [DCW-1:0]  dcnt_ff;
   logic [CW:0]     trial;
   always_comb begin
      trial = {rem_ff[CW-1:0], quo_ff[SUMW-1]};
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         quo_ff  <= sum_ff;
         rem_ff  <= '0;
         dcnt_ff <= DCW'(SUMW);
      end else if (cmd.div_step) begin
         if (trial >= {1'b0, fill_ff}) begin
            rem_ff <= trial - {1'b0, fill_ff};
            quo_ff <= {quo_ff[SUMW-2:0], 1'b1};
         end else begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[SUMW-2:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff - DCW'(1);
      end
   end

   woa_pkg::rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         if (fill_ff == '0) begin
            rsp_ff <= '{empty_res: 1'b1, default: '0};
         end else begin
            rsp_ff.average_speed <= quo_ff[15:0];
            rsp_ff.gust_speed    <= gust_ff;
            rsp_ff.gust_time     <= gust_t_ff;
            rsp_ff.gust_sector   <= gust_s_ff;
            rsp_ff.top_sector    <= 4'(32'(best_ff));
            rsp_ff.elapsed       <= tmax_ff - tmin_ff;
            rsp_ff.empty_res     <= 1'b0;
         end
      end
   end

   assign rsp_data      = rsp_ff;
   assign sts.scan_last = (idx_ff + CW'(1) >= fill_ff);
   assign sts.vote_last = (32'(vsec_ff) == SECTORS - 1);
   assign sts.div_done  = (dcnt_ff == '0);
   assign sts.empty     = (fill_ff == '0);
endmodule

@@ rtl/woa_ctrl.sv @@
// Controller state machine: sequences add, scan, vote, divide, respond.
// Uses woa_pkg command/status structs.
`timescale 1ns / 1ps
module woa_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_opcode,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  woa_pkg::sts_type sts,
   output woa_pkg::cmd_type cmd
);
   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_SCAN, S_VOTE, S_DIV, S_LOAD, S_RESP
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      last_ff;

   wire take = req_valid && req_ready;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd             = '0;
      cmd.write_entry = take && (req_opcode == woa_pkg::OP_ADD);
      cmd.scan_clear  = take && (req_opcode == woa_pkg::OP_AGG);
      case (state_ff)
         S_READ: cmd.scan_read = 1'b1;
         S_SCAN: begin
            cmd.scan_acc  = 1'b1;
            cmd.scan_read = !last_ff;
         end
         S_VOTE: cmd.vote_step = 1'b1;
         S_DIV:  cmd.div_step  = !sts.div_done;
         S_LOAD: cmd.rsp_load  = 1'b1;
         default: ;
      endcase
      cmd.vote_clear = (state_ff == S_SCAN) && last_ff;
      // load the divider on the last vote step; the last speed is in the sum by then
      cmd.div_start  = (state_ff == S_VOTE) && sts.vote_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (take && req_opcode == woa_pkg::OP_AGG) begin
                  state_ff <= sts.empty ? S_LOAD : S_READ;
               end
            end
            S_READ: begin
               last_ff  <= sts.scan_last;
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               // data for the previous read arrives; issue the next read
               if (last_ff) begin
                  state_ff <= S_VOTE;
               end else begin
                  last_ff <= sts.scan_last;
               end
            end
            S_VOTE: begin
               if (sts.vote_last) begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (sts.div_done) begin
                  state_ff <= S_LOAD;
               end
            end
            S_LOAD: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_RESP;
            end
            S_RESP: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ rtl/windowed_observation_aggregator_top.sv @@
// Top level of the windowed observation aggregator.
// Depends on woa_pkg, woa_ctrl, woa_datapath (and woa_ram below it).
//
// Usage:
//  - req channel (req_valid/req_ready/req_data): opcode add stores one
//    observation in the ring; opcode aggregate returns one response.
//  - rsp channel (rsp_valid/rsp_ready/rsp_data): one response per
//    aggregate request, none per add request.
//  - csr channel (csr_valid/csr_ready/csr_data): writes window_size; always
//    ready. Write only while the block is idle.
// Operation:
//  - Add: written in the cycle it is taken; next request may follow at once.
//  - Aggregate: the one-entry-per-cycle RAM scan of the N stored entries,
//    the serial sector vote and the one-bit-per-cycle divider run in turn,
//    then the result register loads and rsp_valid rises; an empty store
//    goes straight to the load.
// Reset: ring empty, write slot 0, window_size 64; no clearing pass.
// Stall: the response holds in its register while rsp_ready is low and no
//  new request is taken until it is delivered.
`timescale 1ns / 1ps
module windowed_observation_aggregator_top #(
   parameter int DEPTH   = woa_pkg::DEPTH_DEF,
   parameter int SECTORS = woa_pkg::SECTORS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  woa_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output woa_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [woa_pkg::WIN_W-1:0] csr_data
);
   woa_pkg::cmd_type cmd;
   woa_pkg::sts_type sts;

   // Register port never stalls
   assign csr_ready = 1'b1;

   woa_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready,
      .req_opcode(req_data.opcode),
      .rsp_valid, .rsp_ready, .sts, .cmd
   );

   woa_datapath #(.DEPTH(DEPTH), .SECTORS(SECTORS)) u_dp (
      .clock, .reset,
      .csr_wr(csr_valid && csr_ready), .csr_data,
      .req_data, .cmd, .sts, .rsp_data
   );

`ifndef SYNTHESIS
   // No request is taken while a response waits
   a_no_take_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken during response");
   // A stalled response keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data)) else $error("rsp changed");
   // An empty response carries zero gust speed and zero elapsed time
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.empty_res |-> rsp_data.gust_speed == '0
      && rsp_data.elapsed == '0) else $error("empty response not zero");
`endif
endmodule

@@ sim/window_stats_checker.sv @@
// Checker for the windowed observation aggregator: watches the request,
// response and csr channels, predicts each summary and compares. Uses woa_pkg.
`timescale 1ns / 1ps
module window_stats_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  woa_pkg::req_type          req_data,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  woa_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   input  logic                      csr_ready,
   input  logic [woa_pkg::WIN_W-1:0] csr_data,
   output int                        mismatch_total,
   output int                        awaiting
);

   localparam int RING    = woa_pkg::DEPTH_DEF;
   localparam int SECTORS = woa_pkg::SECTORS_DEF;

   logic [15:0]               speed_ring [RING];
   logic [31:0]               time_ring [RING];
   logic [7:0]                sector_ring [RING];
   int unsigned               write_slot;
   int unsigned               fill_count;
   logic [woa_pkg::WIN_W-1:0] window_size;
   woa_pkg::rsp_type          expected_summaries [$];

   function automatic int unsigned window_slots();
      int unsigned s;
      s = window_size;
      if (s == 0) s = 1;
      if (s > RING) s = RING;
      return s;
   endfunction

   task automatic store_observation(input woa_pkg::req_type r);
      int unsigned size;
      int unsigned slot;
      size = window_slots();
      slot = write_slot;
      // A slot left outside a shrunken window restarts the ring at zero.
      if (slot >= size) slot = 0;
      speed_ring[slot]  = r.obs_speed;
      time_ring[slot]   = r.obs_time;
      sector_ring[slot] = r.wind_sector;
      slot++;
      if (slot >= size) slot = 0;
      write_slot = slot;
      if (fill_count < size) fill_count++;
   endtask

   function automatic woa_pkg::rsp_type summarize_window();
      int unsigned      votes [SECTORS];
      logic [47:0]      speed_sum;
      logic [15:0]      gust;
      logic [31:0]      gust_t, t_min, t_max;
      logic [7:0]       gust_s;
      int unsigned      best, best_votes;
      woa_pkg::rsp_type r;
      r = '0;
      speed_sum = '0;
      gust = '0;
      gust_t = '0;
      gust_s = '0;
      t_min = '0;
      t_max = '0;
      best = 0;
      best_votes = 0;
      foreach (votes[k]) votes[k] = 0;
      if (fill_count == 0) begin
         r.empty_res = 1'b1;
         return r;
      end
      for (int i = 0; i < fill_count; i++) begin
         speed_sum += speed_ring[i];
         // Ties go to the later entry.
         if (speed_ring[i] >= gust) begin
            gust   = speed_ring[i];
            gust_t = time_ring[i];
            gust_s = sector_ring[i];
         end
         if (sector_ring[i] > 0 && sector_ring[i] < SECTORS) votes[sector_ring[i]]++;
         // A zero minimum means "not yet seen": take the next time as is.
         if (t_min == 0 || time_ring[i] < t_min) t_min = time_ring[i];
         if (time_ring[i] > t_max) t_max = time_ring[i];
      end
      for (int k = 1; k < SECTORS; k++) begin
         if (votes[k] > best_votes) begin
            best_votes = votes[k];
            best = k;
         end
      end
      r.average_speed = 16'(speed_sum / fill_count);
      r.gust_speed    = gust;
      r.gust_time     = gust_t;
      r.gust_sector   = gust_s;
      r.top_sector    = 4'(best);
      r.elapsed       = t_max - t_min;
      r.empty_res     = 1'b0;
      return r;
   endfunction

   always @(posedge clock) begin
      woa_pkg::rsp_type want;
      if (reset) begin
         write_slot  = 0;
         fill_count  = 0;
         window_size = woa_pkg::WIN_RESET;
         expected_summaries.delete();
         mismatch_total <= 0;
      end else begin
         if (csr_valid && csr_ready) window_size = csr_data;
         if (rsp_valid && rsp_ready) begin
            if (expected_summaries.size() == 0) begin
               if (mismatch_total < 10)
                  $display("unexpected response %h", rsp_data);
               mismatch_total <= mismatch_total + 1;
            end else begin
               want = expected_summaries.pop_front();
               if (rsp_data.average_speed !== want.average_speed ||
                   rsp_data.gust_speed    !== want.gust_speed    ||
                   rsp_data.gust_time     !== want.gust_time     ||
                   rsp_data.gust_sector   !== want.gust_sector   ||
                   rsp_data.top_sector    !== want.top_sector    ||
                   rsp_data.elapsed       !== want.elapsed       ||
                   rsp_data.empty_res     !== want.empty_res) begin
                  if (mismatch_total < 10)
                     $display("response mismatch: expected %h, got %h", want, rsp_data);
                  mismatch_total <= mismatch_total + 1;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_data.opcode == woa_pkg::OP_AGG)
               expected_summaries.push_back(summarize_window());
            else store_observation(req_data);
         end
      end
      awaiting <= expected_summaries.size();
   end

endmodule

@@ sim/tb.sv @@
// Testbench top for the windowed observation aggregator: clock, reset,
// request and csr stimulus, response stalls and verdict. Uses woa_pkg,
// window_stats_checker and the block itself.
`timescale 1ns / 1ps
module tb;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int PHASE_ITEMS    = 200;
   localparam int CALM_AFTER     = 1500;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   woa_pkg::req_type          req_data;
   logic                      rsp_valid;
   logic                      rsp_ready;
   woa_pkg::rsp_type          rsp_data;
   logic                      csr_valid;
   logic                      csr_ready;
   logic [woa_pkg::WIN_W-1:0] csr_data;
   int                        mismatch_total;
   int                        awaiting;
   int                        sent;
   int                        idle_cycles;
   logic                      long_hold_done;

   windowed_observation_aggregator_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   window_stats_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .mismatch_total (mismatch_total),
      .awaiting       (awaiting)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Watchdog: count cycles in which no channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Response side: random stall bursts, one long hold-off early on so the
   // block backs up into the request channel, and no stalls near the end.
   initial begin
      rsp_ready = 1'b0;
      long_hold_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!long_hold_done && sent >= 400) begin
            long_hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (600) @(negedge clock);
         end else if (sent < CALM_AFTER && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   function automatic woa_pkg::req_type observation(input logic [15:0] speed,
                                                    input logic [31:0] stamp,
                                                    input logic [7:0] sector);
      woa_pkg::req_type r;
      r.opcode      = woa_pkg::OP_ADD;
      r.obs_speed   = speed;
      r.obs_time    = stamp;
      r.wind_sector = sector;
      return r;
   endfunction

   // Random observation: speeds lean toward a few values so gust ties happen,
   // times include zero to restart minimum tracking, sectors are mostly valid.
   function automatic woa_pkg::req_type random_observation();
      logic [15:0] speed;
      logic [31:0] stamp;
      logic [7:0]  sector;
      case ($urandom_range(0, 3))
         0: speed = 16'($urandom_range(0, 3)) << 8;
         1: speed = 16'hFFFF;
         default: speed = 16'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0: stamp = '0;
         1: stamp = 32'hFFFF_FFFF;
         2, 3: stamp = 32'($urandom_range(1, 1000));
         default: stamp = $urandom;
      endcase
      if ($urandom_range(0, 3) == 0) sector = 8'($urandom);
      else sector = 8'($urandom_range(1, woa_pkg::SECTORS_DEF - 1));
      return observation(speed, stamp, sector);
   endfunction

   // Aggregate request with random don't-care fields.
   function automatic woa_pkg::req_type summary_request();
      woa_pkg::req_type r;
      r = random_observation();
      r.opcode = woa_pkg::OP_AGG;
      return r;
   endfunction

   function automatic woa_pkg::req_type random_request();
      if ($urandom_range(0, 4) == 0) return summary_request();
      return random_observation();
   endfunction

   // Offer one request; hold it until taken. Called and returns at a falling edge.
   task automatic offer(input woa_pkg::req_type r);
      if (sent < CALM_AFTER && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      sent++;
      @(negedge clock);
   endtask

   // Drain, let the block settle, then retune the window.
   task automatic set_window(input logic [woa_pkg::WIN_W-1:0] slots);
      req_valid <= 1'b0;
      while (awaiting != 0) @(negedge clock);
      repeat (150) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= slots;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [woa_pkg::WIN_W-1:0] windows [8];
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      sent = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty store, gust ties, zero and full-scale times,
      // invalid sectors, sector vote tie.
      offer(summary_request());
      offer(observation(16'hFFFF, 32'd100, 8'd3));
      offer(observation(16'hFFFF, 32'd0, 8'd0));
      offer(summary_request());
      offer(observation(16'h0000, 32'hFFFF_FFFF, 8'd15));
      offer(observation(16'h1234, 32'd50, 8'd16));
      offer(observation(16'h0008, 32'd7, 8'd255));
      offer(observation(16'h0080, 32'd7, 8'd3));
      offer(observation(16'h0080, 32'd9, 8'd15));
      offer(summary_request());
      offer(observation(16'h0001, 32'd0, 8'd1));
      offer(observation(16'h0001, 32'd0, 8'd1));
      offer(summary_request());

      // Fill the whole ring once at full width, so later window changes
      // never expose a slot that was never written.
      for (int i = 0; i < woa_pkg::DEPTH_DEF; i++) begin
         offer(random_observation());
         if (i % 8 == 3) offer(summary_request());
      end

      windows = '{7'd1, 7'd0, 7'd127, 7'd64, 7'd2, 7'd63,
                  7'($urandom_range(3, 62)), 7'd5};
      foreach (windows[p]) begin
         set_window(windows[p]);
         for (int i = 0; i < PHASE_ITEMS; i++) offer(random_request());
      end
      req_valid <= 1'b0;

      while (awaiting != 0) @(negedge clock);
      repeat (150) @(negedge clock);
      if (mismatch_total == 0 && awaiting == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
